// File: rtl/bqc_pkg.sv
// bqc_pkg: shared types and constants for the biquad cascade filter
// no dependencies
`default_nettype none

package bqc_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int SECTION_WIDTH  = 5;
   localparam int SLOT_WIDTH     = 3;
   localparam int COEF_IN_WIDTH  = 24;
   localparam int COEF_FRAC      = 20;
   localparam int SLOTS          = 5;
   localparam int STEP_WIDTH     = 3;
   localparam int STEPS          = 5;
   localparam int HEADROOM_BITS  = 8;
   localparam int OUT_FRAC       = 15;

   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_COEF   = 1'b1;

   localparam logic [SLOT_WIDTH-1:0] SLOT_B0 = 3'd0;
   localparam logic [SLOT_WIDTH-1:0] SLOT_B1 = 3'd1;
   localparam logic [SLOT_WIDTH-1:0] SLOT_B2 = 3'd2;
   localparam logic [SLOT_WIDTH-1:0] SLOT_A1 = 3'd3;
   localparam logic [SLOT_WIDTH-1:0] SLOT_A2 = 3'd4;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_D1,
      ST_RD_D2,
      ST_PREP,
      ST_START,
      ST_MUL,
      ST_ACC,
      ST_WB_W,
      ST_WB_D,
      ST_OUT
   } bqc_state_type;

   typedef enum logic [1:0] {
      SIG_D1,
      SIG_D2,
      SIG_W
   } bqc_sig_type;

endpackage

`default_nettype wire

// File: rtl/bqc_req_if.sv
// bqc_req_if: request channel carrying sample and coefficient transactions
// depends on bqc_pkg
`default_nettype none

interface bqc_req_if;
   import bqc_pkg::*;

   logic                              valid;
   logic                              ready;
   logic                              command;
   logic signed [SAMPLE_WIDTH-1:0]    sample;
   logic        [SECTION_WIDTH-1:0]   section;
   logic        [SLOT_WIDTH-1:0]      coef_slot;
   logic signed [COEF_IN_WIDTH-1:0]   coef_value;

   modport source (output valid, command, sample, section, coef_slot, coef_value,
                   input ready);
   modport sink   (input valid, command, sample, section, coef_slot, coef_value,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/bqc_rsp_if.sv
// bqc_rsp_if: response channel carrying filtered and passthrough samples
// depends on bqc_pkg
`default_nettype none

interface bqc_rsp_if;
   import bqc_pkg::*;

   logic                            valid;
   logic                            ready;
   logic signed [SAMPLE_WIDTH-1:0]  filtered;
   logic signed [SAMPLE_WIDTH-1:0]  passthrough;

   modport source (output valid, filtered, passthrough, input ready);
   modport sink   (input valid, filtered, passthrough, output ready);
endinterface

`default_nettype wire

// File: rtl/iir_biquad_cascade_df2.sv
// iir_biquad_cascade_df2: cascade of direct-form-ii biquads on one bit-serial mac
// depends on bqc_pkg, bqc_req_if, bqc_rsp_if, bqc_ram
//
// req_if carries transactions of two kinds. a coefficient transaction writes one
// q3.20 coefficient (b0, b1, b2, a1, a2) of one section and gives no response;
// it is taken whenever the block is idle. a sample transaction runs
// the sample through all sections and gives one rsp_if transaction with the
// filtered sample and the unchanged input sample.
// every product is formed bit-serially: the signal shifts out one bit a cycle
// against the parallel coefficient, after coefficient fetch and load and
// before accumulate. the five products of a section, and the sections of a
// sample, run one after another on the single shared multiplier.
// one sample is in work at a time; req_if.ready is high only when idle.
// the response sits in an output register: the next transaction is taken while
// it waits, and a finished sample waits in its last step while rsp_if stalls.
// after reset the block clears both tables, one entry a cycle, with req_if.ready
// low; delays and coefficients then read zero.
`default_nettype none

module iir_biquad_cascade_df2 #(
   parameter int SECTIONS    = 19,
   parameter int COEF_WIDTH  = 24,
   parameter int STATE_WIDTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   bqc_req_if.sink   req_if,
   bqc_rsp_if.source rsp_if
);
   import bqc_pkg::*;

   localparam int CW       = COEF_WIDTH;
   localparam int SW       = STATE_WIDTH;
   localparam int PW       = CW + SW;
   localparam int PROD_W   = PW - COEF_FRAC;
   localparam int ACC_W    = ((PROD_W > SW) ? PROD_W : SW) + 2;
   localparam int IN_SHIFT = SW - HEADROOM_BITS - OUT_FRAC;
   localparam int Q_W      = SW - IN_SHIFT;
   localparam int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int CDEPTH   = SLOTS * SECTIONS;
   localparam int DDEPTH   = 2 * SECTIONS;
   localparam int CADDR_W  = $clog2(CDEPTH);
   localparam int DADDR_W  = $clog2(DDEPTH);
   localparam int BIT_W    = $clog2(SW);
   localparam int WADDR_W  = 9;

   bqc_state_type state_ff, state_in;

   logic [CADDR_W-1:0]             clr_cnt_ff;
   logic [SEC_W-1:0]               sec_ff;
   logic [STEP_WIDTH-1:0]          k_ff;
   logic [BIT_W-1:0]               bit_cnt_ff;
   logic signed [SW-1:0]           x_ff, w_ff, d1_ff, d2_ff;
   logic signed [ACC_W-1:0]        acc_ff;
   logic signed [CW-1:0]           c_ff;
   logic [SW-1:0]                  sreg_ff;
   logic [PW-1:0]                  p_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] filtered_ff, passthrough_ff;

   logic                    req_accept, rsp_free, last_bit, last_sec, clr_done;
   logic                    coef_wr_ok;
   logic [SLOT_WIDTH-1:0]   slot_sel;
   bqc_sig_type             sig_sel;
   logic                    sub_sel;
   logic signed [SW-1:0]    sig_val;
   logic signed [CW-1:0]    coef_wr_val;
   logic [CADDR_W-1:0]      sec_base;
   logic [CADDR_W-1:0]      coef_wr_addr;
   logic signed [CW:0]      partial;
   logic signed [ACC_W-1:0] prod_ext, acc_sum;
   logic signed [SW-1:0]    acc_sat;
   logic signed [Q_W:0]     q_val;
   logic signed [SAMPLE_WIDTH-1:0] q_sat;

   logic                    c_we, d_we;
   logic [CADDR_W-1:0]      c_waddr, c_raddr;
   logic [CW-1:0]           c_wdata, c_rdata;
   logic [DADDR_W-1:0]      d_waddr, d_raddr;
   logic [SW-1:0]           d_wdata, d_rdata;

   function automatic logic signed [SW-1:0] sat_state(input logic signed [ACC_W-1:0] v);
      logic signed [SW-1:0] r;
      if (&v[ACC_W-1:SW-1] || ~|v[ACC_W-1:SW-1]) begin
         r = v[SW-1:0];
      end else if (v[ACC_W-1]) begin
         r = {1'b1, {(SW-1){1'b0}}};
      end else begin
         r = {1'b0, {(SW-1){1'b1}}};
      end
      return r;
   endfunction

   generate
      if (CW <= COEF_IN_WIDTH) begin : g_coef_narrow
         assign coef_wr_val = req_if.coef_value[CW-1:0];
      end else begin : g_coef_wide
         assign coef_wr_val = {{(CW-COEF_IN_WIDTH){req_if.coef_value[COEF_IN_WIDTH-1]}},
                               req_if.coef_value};
      end
   endgenerate

   assign req_accept = req_if.valid && req_if.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_if.ready;
   assign last_bit   = (bit_cnt_ff == BIT_W'(SW - 1));
   assign last_sec   = (sec_ff == SEC_W'(SECTIONS - 1));
   assign clr_done   = (clr_cnt_ff == CADDR_W'(CDEPTH - 1));
   assign coef_wr_ok = (32'(req_if.section) < 32'(SECTIONS)) &&
                       (req_if.coef_slot < 3'(SLOTS));
   assign coef_wr_addr = CADDR_W'(WADDR_W'(req_if.section) * WADDR_W'(SLOTS) +
                                  WADDR_W'(req_if.coef_slot));
   assign sec_base   = (CADDR_W'(sec_ff) << 2) + CADDR_W'(sec_ff);

   // product schedule: a1*d1, a2*d2, b0*w, b1*d1, b2*d2
   always_comb begin
      case (k_ff)
         3'd0:    begin slot_sel = SLOT_A1; sig_sel = SIG_D1; sub_sel = 1'b1; end
         3'd1:    begin slot_sel = SLOT_A2; sig_sel = SIG_D2; sub_sel = 1'b1; end
         3'd2:    begin slot_sel = SLOT_B0; sig_sel = SIG_W;  sub_sel = 1'b0; end
         3'd3:    begin slot_sel = SLOT_B1; sig_sel = SIG_D1; sub_sel = 1'b0; end
         3'd4:    begin slot_sel = SLOT_B2; sig_sel = SIG_D2; sub_sel = 1'b0; end
         default: begin slot_sel = SLOT_B0; sig_sel = SIG_D1; sub_sel = 1'b0; end
      endcase
   end

   always_comb begin
      case (sig_sel)
         SIG_D1:  sig_val = d1_ff;
         SIG_D2:  sig_val = d2_ff;
         SIG_W:   sig_val = w_ff;
         default: sig_val = d1_ff;
      endcase
   end

   // serial-parallel multiply step, msb of the signal carries negative weight
   always_comb begin
      if (!sreg_ff[0]) begin
         partial = {p_ff[PW-1], p_ff[PW-1:SW]};
      end else if (last_bit) begin
         partial = {p_ff[PW-1], p_ff[PW-1:SW]} - {c_ff[CW-1], c_ff};
      end else begin
         partial = {p_ff[PW-1], p_ff[PW-1:SW]} + {c_ff[CW-1], c_ff};
      end
   end

   assign prod_ext = {{(ACC_W-PROD_W){p_ff[PW-1]}}, p_ff[PW-1:COEF_FRAC]};
   assign acc_sum  = sub_sel ? (acc_ff - prod_ext) : (acc_ff + prod_ext);
   assign acc_sat  = sat_state(acc_sum);

   // output: truncate toward zero, then saturate to 16 bits
   assign q_val = {x_ff[SW-1], x_ff[SW-1:IN_SHIFT]} +
                  (Q_W+1)'(x_ff[SW-1] && (|x_ff[IN_SHIFT-1:0]));
   always_comb begin
      if (&q_val[Q_W:SAMPLE_WIDTH-1] || ~|q_val[Q_W:SAMPLE_WIDTH-1]) begin
         q_sat = q_val[SAMPLE_WIDTH-1:0];
      end else if (q_val[Q_W]) begin
         q_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         q_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_done) state_in = ST_IDLE;
         ST_IDLE:  if (req_accept && req_if.command == CMD_FILTER) state_in = ST_RD_D1;
         ST_RD_D1: state_in = ST_RD_D2;
         ST_RD_D2: state_in = ST_PREP;
         ST_PREP:  state_in = ST_START;
         ST_START: state_in = ST_MUL;
         ST_MUL:   if (last_bit) state_in = ST_ACC;
         ST_ACC:   state_in = (k_ff == STEP_WIDTH'(STEPS - 1)) ? ST_WB_W : ST_PREP;
         ST_WB_W:  state_in = ST_WB_D;
         ST_WB_D:  state_in = last_sec ? ST_OUT : ST_RD_D1;
         ST_OUT:   if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // table ports and handshake outputs
   always_comb begin
      c_we    = 1'b0;
      c_waddr = coef_wr_addr;
      c_wdata = coef_wr_val;
      c_raddr = sec_base + CADDR_W'(slot_sel);
      d_we    = 1'b0;
      d_waddr = DADDR_W'({sec_ff, 1'b0});
      d_wdata = w_ff;
      d_raddr = DADDR_W'({sec_ff, 1'b0});
      case (state_ff)
         ST_CLEAR: begin
            c_we    = 1'b1;
            c_waddr = clr_cnt_ff;
            c_wdata = '0;
            d_we    = (32'(clr_cnt_ff) < 32'(DDEPTH));
            d_waddr = clr_cnt_ff[DADDR_W-1:0];
            d_wdata = '0;
         end
         ST_IDLE: begin
            c_we = req_accept && (req_if.command == CMD_COEF) && coef_wr_ok;
         end
         ST_RD_D2: begin
            d_raddr = DADDR_W'({sec_ff, 1'b1});
         end
         ST_WB_W: begin
            d_we = 1'b1;
         end
         ST_WB_D: begin
            d_we    = 1'b1;
            d_waddr = DADDR_W'({sec_ff, 1'b1});
            d_wdata = d1_ff;
         end
         default: begin
            c_we = 1'b0;
         end
      endcase
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.filtered    = filtered_ff;
   assign rsp_if.passthrough = passthrough_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + CADDR_W'(1);
         end
         if (state_ff == ST_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            sec_ff    <= '0;
            sample_ff <= req_if.sample;
            x_ff      <= {{(HEADROOM_BITS-1){req_if.sample[SAMPLE_WIDTH-1]}},
                          req_if.sample, {IN_SHIFT{1'b0}}};
         end
         ST_RD_D1: begin
            acc_ff <= {{(ACC_W-SW){x_ff[SW-1]}}, x_ff};
            k_ff   <= '0;
         end
         ST_RD_D2: begin
            d1_ff <= d_rdata;
         end
         ST_PREP: begin
            if (k_ff == '0) begin
               d2_ff <= d_rdata;
            end
         end
         ST_START: begin
            c_ff       <= c_rdata;
            sreg_ff    <= sig_val;
            p_ff       <= '0;
            bit_cnt_ff <= '0;
         end
         ST_MUL: begin
            p_ff       <= {partial, p_ff[SW-1:1]};
            sreg_ff    <= {1'b0, sreg_ff[SW-1:1]};
            bit_cnt_ff <= bit_cnt_ff + BIT_W'(1);
         end
         ST_ACC: begin
            k_ff <= k_ff + STEP_WIDTH'(1);
            if (k_ff == STEP_WIDTH'(1)) begin
               w_ff   <= acc_sat;
               acc_ff <= '0;
            end else begin
               acc_ff <= acc_sum;
            end
            if (k_ff == STEP_WIDTH'(STEPS - 1)) begin
               x_ff <= acc_sat;
            end
         end
         ST_WB_D: begin
            sec_ff <= sec_ff + SEC_W'(1);
         end
         ST_OUT: begin
            if (rsp_free) begin
               filtered_ff    <= q_sat;
               passthrough_ff <= sample_ff;
            end
         end
         default: begin
            sec_ff <= sec_ff;
         end
      endcase
   end

   bqc_ram #(.WIDTH(CW), .DEPTH(CDEPTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_addr (c_raddr),
      .rd_data (c_rdata)
   );

   bqc_ram #(.WIDTH(SW), .DEPTH(DDEPTH)) u_delay_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_addr (d_raddr),
      .rd_data (d_rdata)
   );
endmodule

`default_nettype wire

// File: rtl/bqc_ram.sv
// bqc_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module bqc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 38
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

`default_nettype wire

// File: rtl/bqc_checker.sv
// bqc_checker: port-level checks for the biquad cascade, bound to the top level
// depends on bqc_pkg and iir_biquad_cascade_df2
`default_nettype none

module bqc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_command,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);
   import bqc_pkg::*;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // table clear keeps the request side closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during table clear");

   // a coefficient transaction never produces a response
   a_coef_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_command == CMD_COEF && !rsp_valid) |=> !rsp_valid)
      else $error("response after coefficient transaction");

   // a sample transaction starts a multi-cycle run
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_command == CMD_FILTER) |=> !req_ready)
      else $error("request ready right after sample transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");
endmodule

bind iir_biquad_cascade_df2 bqc_checker u_bqc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .req_command (req_if.command),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready)
);

`default_nettype wire

// File: verif/iir_biquad_cascade_df2_tb.sv
// iir_biquad_cascade_df2_tb: self-checking bench for the biquad cascade filter
// drives sample and coefficient transactions, predicts each filtered sample
// depends on bqc_pkg, bqc_req_if, bqc_rsp_if and iir_biquad_cascade_df2
`default_nettype none

module iir_biquad_cascade_df2_tb;
   import bqc_pkg::*;

   localparam int NUM_SECTIONS = 19;
   localparam int STATE_BITS   = 32;
   localparam int IN_SHIFT     = STATE_BITS - HEADROOM_BITS - OUT_FRAC;
   localparam longint STATE_MAX = (64'sd1 <<< (STATE_BITS - 1)) - 1;
   localparam longint STATE_MIN = -STATE_MAX - 1;
   localparam logic signed [COEF_IN_WIDTH-1:0] COEF_ONE = 24'sd1 <<< COEF_FRAC;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] filtered;
      logic signed [SAMPLE_WIDTH-1:0] passthrough;
   } audio_out_type;

   logic clock;
   logic reset;
   bqc_req_if req_if();
   bqc_rsp_if rsp_if();

   iir_biquad_cascade_df2 dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   longint        delay_d1 [NUM_SECTIONS];
   longint        delay_d2 [NUM_SECTIONS];
   longint        coef_table [NUM_SECTIONS][SLOTS];
   audio_out_type pending_outputs [$];
   int            error_count = 0;
   int            idle_pct = 0;
   int            stall_pct = 0;
   int            hold_request = 0;
   int            hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #80000000;
      $display("Verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic longint sat_state(input longint v);
      if (v > STATE_MAX) return STATE_MAX;
      if (v < STATE_MIN) return STATE_MIN;
      return v;
   endfunction

   function automatic longint coef_mul(input longint c, input longint s);
      return (c * s) >>> COEF_FRAC;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] cascade_filter(
         input logic signed [SAMPLE_WIDTH-1:0] sample);
      longint x, w, d1, d2, mag, q;
      x = longint'(sample) <<< IN_SHIFT;
      for (int s = 0; s < NUM_SECTIONS; s++) begin
         d1 = delay_d1[s];
         d2 = delay_d2[s];
         w = sat_state(x - coef_mul(coef_table[s][SLOT_A1], d1)
                         - coef_mul(coef_table[s][SLOT_A2], d2));
         x = sat_state(coef_mul(coef_table[s][SLOT_B0], w)
                       + coef_mul(coef_table[s][SLOT_B1], d1)
                       + coef_mul(coef_table[s][SLOT_B2], d2));
         delay_d2[s] = d1;
         delay_d1[s] = w;
      end
      mag = (x < 0) ? -x : x;
      q = mag >>> IN_SHIFT;
      if (x < 0) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[SAMPLE_WIDTH-1:0];
   endfunction

   task automatic send_item(input logic cmd, input logic signed [SAMPLE_WIDTH-1:0] sample,
                            input logic [SECTION_WIDTH-1:0] section,
                            input logic [SLOT_WIDTH-1:0] slot,
                            input logic signed [COEF_IN_WIDTH-1:0] value);
      audio_out_type want;
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.command    <= cmd;
      req_if.sample     <= sample;
      req_if.section    <= section;
      req_if.coef_slot  <= slot;
      req_if.coef_value <= value;
      do @(posedge clock); while (!req_if.ready);
      if (cmd == CMD_COEF) begin
         if (section < NUM_SECTIONS && slot < SLOTS)
            coef_table[section][slot] = longint'(value);
      end else begin
         want.filtered    = cascade_filter(sample);
         want.passthrough = sample;
         pending_outputs.push_back(want);
      end
   endtask

   task automatic write_coef(input int section, input int slot,
                             input logic signed [COEF_IN_WIDTH-1:0] value);
      send_item(CMD_COEF, SAMPLE_WIDTH'($urandom), SECTION_WIDTH'(section),
                SLOT_WIDTH'(slot), value);
   endtask

   task automatic filter_sample(input logic signed [SAMPLE_WIDTH-1:0] sample);
      send_item(CMD_FILTER, sample, SECTION_WIDTH'($urandom), SLOT_WIDTH'($urandom),
                COEF_IN_WIDTH'($urandom));
   endtask

   function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return SAMPLE_WIDTH'($signed($urandom_range(255)) - 128);
         default: return SAMPLE_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic signed [COEF_IN_WIDTH-1:0] random_coef(input int slot);
      if ($urandom_range(9) == 0) return COEF_IN_WIDTH'($urandom);
      if (slot == SLOT_B0)
         return COEF_IN_WIDTH'(COEF_ONE + $signed($urandom_range(1 << 18)) - (1 << 17));
      return COEF_IN_WIDTH'($signed($urandom_range(1 << 18)) - (1 << 17));
   endfunction

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      audio_out_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_outputs.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_if.filtered, 0);
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_if.filtered !== want.filtered)
               report_mismatch("filtered", rsp_if.filtered, want.filtered);
            if (rsp_if.passthrough !== want.passthrough)
               report_mismatch("passthrough", rsp_if.passthrough, want.passthrough);
         end
      end
   end

   task automatic test_zero_table();
      filter_sample(16'sh7fff);
      filter_sample(16'sh8000);
      write_coef(NUM_SECTIONS, SLOT_B0, COEF_ONE);
      write_coef(31, SLOT_B0, COEF_ONE);
      write_coef(0, 5, COEF_ONE);
      write_coef(0, 7, COEF_ONE);
      filter_sample(16'sd1234);
   endtask

   task automatic test_saturation();
      for (int s = 0; s < NUM_SECTIONS; s++)
         write_coef(s, SLOT_B0, 24'sh7fffff);
      write_coef(0, SLOT_B1, 24'sh800000);
      filter_sample(16'sh7fff);
      filter_sample(16'sh8000);
      filter_sample(16'sd1);
   endtask

   task automatic test_random_filters(input int sets, input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
      for (int n = 0; n < sets; n++) begin
         int slot;
         repeat (66) begin
            slot = $urandom_range(SLOTS - 1);
            if ($urandom_range(9) == 0)
               write_coef($urandom_range(31), $urandom_range(7), COEF_IN_WIDTH'($urandom));
            else
               write_coef($urandom_range(NUM_SECTIONS - 1), slot, random_coef(slot));
         end
         repeat (6) filter_sample(random_sample());
      end
   endtask

   task automatic test_output_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      hold_request = 12000;
      repeat (5) filter_sample(random_sample());
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid      <= 1'b0;
      req_if.command    <= CMD_FILTER;
      req_if.sample     <= '0;
      req_if.section    <= '0;
      req_if.coef_slot  <= '0;
      req_if.coef_value <= '0;
      foreach (coef_table[s, k]) coef_table[s][k] = 0;
      foreach (delay_d1[s]) begin
         delay_d1[s] = 0;
         delay_d2[s] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_zero_table();
      test_saturation();
      test_random_filters(5, 0, 0);
      test_random_filters(5, 56, 0);
      test_random_filters(5, 0, 56);
      test_random_filters(5, 38, 38);
      test_output_backpressure();
      test_random_filters(2, 0, 0);
      req_if.valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
